// ----- rtl/lmssc_pkg.sv -----
// Package for the LFSR / multiplexer / substitution stream cipher core.
// Holds LFSR geometry, the substitution table, request and CSR codes.
// No dependencies.
`timescale 1ns / 1ps

package lmssc_pkg;

   // Eight generators, each kept as a window of its length plus six look-ahead bits.
   localparam int unsigned LFSR_COUNT = 8;
   localparam int unsigned WIN_EXTRA  = 6;
   localparam int unsigned KEY_BITS   = 288;

   localparam int unsigned LFSR_LEN [LFSR_COUNT] = '{41, 29, 39, 31, 35, 28, 49, 36};
   localparam int unsigned LFSR_TAP [LFSR_COUNT] = '{3, 2, 4, 3, 2, 3, 9, 11};

   // Offsets into the role pattern: bit i mixes generators i, i+3 and i+5 (mod 8).
   localparam int unsigned MIX_B_OFFSET = 3;
   localparam int unsigned MIX_C_OFFSET = 5;

   // Request codes.
   localparam logic REQ_RELOAD = 1'b0;
   localparam logic REQ_CIPHER = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 64;
   localparam int unsigned KEY_TAIL_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_0_7   = 3'd0,
      CSR_KEY_8_15  = 3'd1,
      CSR_KEY_16_23 = 3'd2,
      CSR_KEY_24_31 = 3'd3,
      CSR_KEY_32_35 = 3'd4
   } csr_index_type;

   // Control of one generator window.
   typedef struct packed {
      logic load;
      logic shift;
   } win_ctrl_type;

   // First key bit used by generator idx: sum of the lengths before it.
   function automatic int unsigned lfsr_offset(input int unsigned idx);
      int unsigned sum;
      sum = 0;
      for (int unsigned k = 0; k < LFSR_COUNT; k++) begin
         if (k < idx) begin
            sum += LFSR_LEN[k];
         end
      end
      return sum;
   endfunction

   // Byte substitution table.
   localparam logic [7:0] SBOX [256] = '{
      8'd99,  8'd217, 8'd3,   8'd113, 8'd189, 8'd127, 8'd235, 8'd224,
      8'd120, 8'd142, 8'd79,  8'd78,  8'd24,  8'd45,  8'd218, 8'd177,
      8'd198, 8'd141, 8'd203, 8'd51,  8'd251, 8'd181, 8'd163, 8'd112,
      8'd4,   8'd67,  8'd91,  8'd216, 8'd240, 8'd164, 8'd124, 8'd146,
      8'd28,  8'd172, 8'd81,  8'd75,  8'd61,  8'd36,  8'd212, 8'd93,
      8'd144, 8'd11,  8'd26,  8'd237, 8'd219, 8'd94,  8'd44,  8'd66,
      8'd35,  8'd122, 8'd173, 8'd135, 8'd100, 8'd73,  8'd200, 8'd76,
      8'd145, 8'd117, 8'd211, 8'd126, 8'd92,  8'd132, 8'd202, 8'd232,
      8'd82,  8'd154, 8'd210, 8'd129, 8'd201, 8'd8,   8'd41,  8'd214,
      8'd152, 8'd161, 8'd182, 8'd220, 8'd98,  8'd1,   8'd248, 8'd187,
      8'd239, 8'd231, 8'd77,  8'd85,  8'd68,  8'd165, 8'd25,  8'd138,
      8'd155, 8'd27,  8'd30,  8'd206, 8'd43,  8'd131, 8'd209, 8'd125,
      8'd195, 8'd140, 8'd153, 8'd225, 8'd247, 8'd37,  8'd207, 8'd255,
      8'd80,  8'd84,  8'd188, 8'd33,  8'd22,  8'd7,   8'd167, 8'd105,
      8'd16,  8'd72,  8'd108, 8'd139, 8'd13,  8'd34,  8'd168, 8'd242,
      8'd191, 8'd160, 8'd205, 8'd107, 8'd147, 8'd169, 8'd47,  8'd49,
      8'd171, 8'd222, 8'd101, 8'd159, 8'd70,  8'd204, 8'd223, 8'd233,
      8'd38,  8'd236, 8'd65,  8'd234, 8'd254, 8'd151, 8'd118, 8'd19,
      8'd57,  8'd229, 8'd158, 8'd116, 8'd20,  8'd150, 8'd40,  8'd197,
      8'd137, 8'd143, 8'd10,  8'd157, 8'd14,  8'd175, 8'd252, 8'd123,
      8'd136, 8'd134, 8'd64,  8'd246, 8'd42,  8'd21,  8'd62,  8'd111,
      8'd249, 8'd149, 8'd109, 8'd90,  8'd60,  8'd128, 8'd186, 8'd199,
      8'd88,  8'd87,  8'd48,  8'd253, 8'd102, 8'd148, 8'd74,  8'd133,
      8'd58,  8'd213, 8'd23,  8'd54,  8'd115, 8'd121, 8'd228, 8'd31,
      8'd174, 8'd55,  8'd0,   8'd170, 8'd185, 8'd166, 8'd190, 8'd178,
      8'd18,  8'd59,  8'd179, 8'd110, 8'd196, 8'd245, 8'd238, 8'd162,
      8'd156, 8'd63,  8'd53,  8'd130, 8'd71,  8'd15,  8'd184, 8'd12,
      8'd97,  8'd89,  8'd5,   8'd183, 8'd17,  8'd104, 8'd106, 8'd103,
      8'd250, 8'd243, 8'd9,   8'd50,  8'd56,  8'd114, 8'd227, 8'd86,
      8'd29,  8'd180, 8'd208, 8'd244, 8'd96,  8'd241, 8'd52,  8'd32,
      8'd83,  8'd221, 8'd95,  8'd192, 8'd2,   8'd193, 8'd6,   8'd230,
      8'd226, 8'd46,  8'd176, 8'd119, 8'd215, 8'd194, 8'd39,  8'd69
   };

endpackage

// ----- rtl/lmssc_req_if.sv -----
// Channel interfaces for the stream cipher core: request and response.
// Depends on nothing; both carry valid/ready and the payload.
`timescale 1ns / 1ps

interface lmssc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface lmssc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cipher_byte;

   modport source (output valid, output cipher_byte, input ready);
   modport sink (input valid, input cipher_byte, output ready);
endinterface

// ----- rtl/lmssc_window.sv -----
// One LFSR held as a sliding window of its length plus six look-ahead bits.
// Depends on lmssc_pkg for the window control struct and the look-ahead size.
`timescale 1ns / 1ps

module lmssc_window
   import lmssc_pkg::*;
#(
   parameter int unsigned Len = LFSR_LEN[0],
   parameter int unsigned Tap = LFSR_TAP[0]
) (
   input  logic           clock,
   input  logic           reset,
   input  win_ctrl_type   ctrl,
   input  logic [Len-1:0] seed,
   output logic           tap_a,
   output logic           tap_b,
   output logic           tap_c
);

   localparam int unsigned Width = Len + WIN_EXTRA;

   logic [Width-1:0] win_ff;
   logic [Width-1:0] win_in;
   logic [Width-1:0] seed_win;
   logic [Width-1:0] shift_win;

   // Seed from the key and extend it by six steps of x[j] = x[j-tap] ^ x[j-len].
   always_comb begin
      seed_win = '0;
      seed_win[Len-1:0] = seed;
      for (int unsigned j = Len; j < Width; j++) begin
         seed_win[j] = seed_win[j-Tap] ^ seed_win[j-Len];
      end
   end

   // One step of the recurrence: drop the oldest bit, append the newest.
   assign shift_win = {win_ff[Width-Tap] ^ win_ff[WIN_EXTRA], win_ff[Width-1:1]};

   always_comb begin
      win_in = win_ff;
      if (ctrl.load) begin
         win_in = seed_win;
      end else if (ctrl.shift) begin
         win_in = shift_win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // The three positions read for the current byte.
   assign tap_a = win_ff[Len];
   assign tap_b = win_ff[Len+2];
   assign tap_c = win_ff[Len+5];

endmodule

// ----- rtl/lfsr_mux_sbox_stream_cipher_core.sv -----
// Top level of the LFSR / multiplexer / substitution stream cipher core.
// Depends on lmssc_pkg, the channel interfaces and lmssc_window.
`timescale 1ns / 1ps

// Usage:
// A 288-bit key is written through the CSR port (csr_wr_en, csr_index, csr_wdata)
// into five key registers; a write takes effect at the next reload transaction.
// Request transactions on req_if carry req_type and data_byte. A reload
// transaction (req_type 0) seeds the eight LFSR windows from the key and gives
// no response. A cipher transaction (req_type 1) gives one response transaction
// on rsp_if whose cipher_byte is data_byte XOR the keystream byte of the current
// position, then steps every LFSR once.
// Latency: a response is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the keystream is computed in one pass
// through the mux stage and three table reads into the response register.
// When the receiver stalls, the response register holds its transaction and
// req_if.ready drops until it is taken; it is high whenever the register is
// empty or being emptied in the same cycle.
// Reset (synchronous, active high) clears the key registers, the windows and
// the response valid; ciphering before any reload uses all-zero windows.

module lfsr_mux_sbox_stream_cipher_core
   import lmssc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   lmssc_req_if.sink                  req_if,
   lmssc_rsp_if.source                rsp_if,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [CSR_DATA_WIDTH-1:0] key_ff [4];
   logic [KEY_TAIL_WIDTH-1:0] key_tail_ff;
   logic [KEY_BITS-1:0]       key_cat;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [7:0]            rsp_byte_ff;
   logic [7:0]            rsp_byte_in;

   logic                  req_accept;
   win_ctrl_type          win_ctrl;
   logic [LFSR_COUNT-1:0] tap_a;
   logic [LFSR_COUNT-1:0] tap_b;
   logic [LFSR_COUNT-1:0] tap_c;
   logic [7:0]            mix_u;
   logic [7:0]            mix_v;
   logic [7:0]            mix_w;
   logic [7:0]            keystream;

   // Key registers; indexes outside the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned r = 0; r < 4; r++) begin
            key_ff[r] <= '0;
         end
         key_tail_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_0_7:   key_ff[0] <= csr_wdata;
            CSR_KEY_8_15:  key_ff[1] <= csr_wdata;
            CSR_KEY_16_23: key_ff[2] <= csr_wdata;
            CSR_KEY_24_31: key_ff[3] <= csr_wdata;
            CSR_KEY_32_35: key_tail_ff <= csr_wdata[KEY_TAIL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Key bit g sits at key_cat[KEY_BITS-1-g].
   assign key_cat = {key_ff[0], key_ff[1], key_ff[2], key_ff[3], key_tail_ff};

   // Handshake: take a request whenever the response register is free this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   assign win_ctrl.load  = req_accept && (req_if.req_type == REQ_RELOAD);
   assign win_ctrl.shift = req_accept && (req_if.req_type == REQ_CIPHER);

   // The eight generator windows, each seeded MSB-first from its slice of the key.
   for (genvar i = 0; i < LFSR_COUNT; i++) begin : g_lfsr
      localparam int unsigned Len    = LFSR_LEN[i];
      localparam int unsigned Offset = lfsr_offset(i);
      logic [Len-1:0] seed;

      for (genvar j = 0; j < Len; j++) begin : g_seed
         assign seed[j] = key_cat[KEY_BITS-1-Offset-j];
      end

      lmssc_window #(
         .Len (Len),
         .Tap (LFSR_TAP[i])
      ) u_window (
         .clock (clock),
         .reset (reset),
         .ctrl  (win_ctrl),
         .seed  (seed),
         .tap_a (tap_a[i]),
         .tap_b (tap_b[i]),
         .tap_c (tap_c[i])
      );
   end

   // Bitwise multiplexer stage: bit i takes a from LFSR i, b from i+3, c from i+5.
   always_comb begin
      for (int unsigned i = 0; i < LFSR_COUNT; i++) begin
         logic a;
         logic b;
         logic c;
         a = tap_a[i];
         b = tap_b[(i + MIX_B_OFFSET) % LFSR_COUNT];
         c = tap_c[(i + MIX_C_OFFSET) % LFSR_COUNT];
         mix_u[i] = c ? a : b;
         mix_v[i] = a ? b : c;
         mix_w[i] = b ? c : a;
      end
   end

   assign keystream   = SBOX[mix_u] ^ SBOX[mix_v] ^ SBOX[mix_w];
   assign rsp_byte_in = req_if.data_byte ^ keystream;

   // Response register: loads on a cipher transaction, clears when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (win_ctrl.shift) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_ctrl.shift) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.cipher_byte = rsp_byte_ff;

   // A cipher transaction always leaves a response waiting in the next cycle.
   a_cipher_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      win_ctrl.shift |=> rsp_if.valid)
      else $error("cipher transaction did not produce a response");

   // A reload into a free response register never produces a response.
   a_reload_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (win_ctrl.load && !(rsp_if.valid && !rsp_if.ready)) |=> !rsp_if.valid)
      else $error("reload transaction produced a response");

   // An empty response register never blocks requests.
   a_ready_when_empty: assert property (@(posedge clock)
      !rsp_if.valid |-> req_if.ready)
      else $error("request blocked with empty response register");

   // Load and step of the windows are never requested together.
   a_ctrl_exclusive: assert property (@(posedge clock)
      !(win_ctrl.load && win_ctrl.shift))
      else $error("window load and shift in the same cycle");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the LFSR / multiplexer / substitution stream cipher core.
// Depends on lmssc_pkg, the request/response channel interfaces and the core itself.
`timescale 1ns / 1ps

module testbench;
   import lmssc_pkg::*;

   // Longest generator window: 49 bits plus the look-ahead bits.
   localparam int WIN_BITS    = 49 + WIN_EXTRA;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_LIMIT = 2000;
   localparam int PHASE_ITEMS = 100;

   typedef struct {
      logic       req_type;
      logic [7:0] data_byte;
   } cipher_req_type;

   logic clock;
   logic reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   lmssc_req_if req_if ();
   lmssc_rsp_if rsp_if ();

   lfsr_mux_sbox_stream_cipher_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: key registers and the eight generator windows.
   logic [63:0]         key_reg [5];
   logic [WIN_BITS-1:0] lfsr_win [LFSR_COUNT];

   cipher_req_type pending_reqs [$];
   logic [7:0]     expected_bytes [$];
   cipher_req_type next_req;

   bit idle_en;
   int send_gap;
   int stall_left;
   int mismatch_count;
   int cycle_count;

   // The clock starts low so that the first rising edge comes after time zero.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // Seed every window from the 288-bit key, MSB first, and fill its look-ahead bits.
   function automatic void reseed_windows();
      logic [KEY_BITS-1:0] key_vec;
      int unsigned base;
      int unsigned len;
      int unsigned tap;
      key_vec = {key_reg[0], key_reg[1], key_reg[2], key_reg[3], key_reg[4][31:0]};
      base = 0;
      for (int unsigned i = 0; i < LFSR_COUNT; i++) begin
         len = LFSR_LEN[i];
         tap = LFSR_TAP[i];
         lfsr_win[i] = '0;
         for (int unsigned j = 0; j < len; j++) begin
            lfsr_win[i][j] = key_vec[KEY_BITS - 1 - base - j];
         end
         for (int unsigned j = len; j < len + WIN_EXTRA; j++) begin
            lfsr_win[i][j] = lfsr_win[i][j - tap] ^ lfsr_win[i][j - len];
         end
         base += len;
      end
   endfunction

   // Slide every window one position along its trinomial recurrence.
   function automatic void step_windows();
      int unsigned len;
      int unsigned tap;
      logic fresh;
      for (int unsigned i = 0; i < LFSR_COUNT; i++) begin
         len = LFSR_LEN[i];
         tap = LFSR_TAP[i];
         fresh = lfsr_win[i][len + WIN_EXTRA - tap] ^ lfsr_win[i][WIN_EXTRA];
         lfsr_win[i] = lfsr_win[i] >> 1;
         lfsr_win[i][len + WIN_EXTRA - 1] = fresh;
      end
   endfunction

   // Keystream byte of the current position XOR the data byte, then advance.
   function automatic logic [7:0] next_cipher_byte(input logic [7:0] data);
      logic [7:0] sel_u;
      logic [7:0] sel_v;
      logic [7:0] sel_w;
      logic a;
      logic b;
      logic c;
      int unsigned h;
      int unsigned g;
      for (int unsigned i = 0; i < LFSR_COUNT; i++) begin
         h = (i + MIX_B_OFFSET) % LFSR_COUNT;
         g = (i + MIX_C_OFFSET) % LFSR_COUNT;
         a = lfsr_win[i][LFSR_LEN[i]];
         b = lfsr_win[h][LFSR_LEN[h] + 2];
         c = lfsr_win[g][LFSR_LEN[g] + 5];
         sel_u[i] = c ? a : b;
         sel_v[i] = a ? b : c;
         sel_w[i] = b ? c : a;
      end
      step_windows();
      return SBOX[sel_u] ^ SBOX[sel_v] ^ SBOX[sel_w] ^ data;
   endfunction

   // Request driver: predicts each accepted transaction, then loads the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.req_type == REQ_CIPHER) begin
               expected_bytes.insert(expected_bytes.size(),
                                     next_cipher_byte(req_if.data_byte));
            end else begin
               reseed_windows();
            end
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
               if (send_gap > 0) begin
                  send_gap--;
               end
               req_if.valid <= 1'b0;
            end else begin
               next_req = pending_reqs.pop_front();
               req_if.valid     <= 1'b1;
               req_if.req_type  <= next_req.req_type;
               req_if.data_byte <= next_req.data_byte;
               if (idle_en && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Response monitor: compares each transaction with the oldest expected byte.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_bytes.size() == 0) begin
               log_mismatch($sformatf("unexpected cipher_byte %02h", rsp_if.cipher_byte));
            end else if (rsp_if.cipher_byte !== expected_bytes[0]) begin
               log_mismatch($sformatf("cipher_byte %02h, expected %02h",
                                      rsp_if.cipher_byte, expected_bytes[0]));
               void'(expected_bytes.pop_front());
            end else begin
               void'(expected_bytes.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idle_en && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 6);
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic void queue_req(input logic kind, input logic [7:0] data);
      cipher_req_type item;
      item.req_type  = kind;
      item.data_byte = data;
      pending_reqs.insert(pending_reqs.size(), item);
   endfunction

   // Mostly long cipher runs with an occasional reload in between.
   function automatic void queue_random(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 29) == 0) begin
            queue_req(REQ_RELOAD, 8'($urandom_range(0, 255)));
         end else begin
            queue_req(REQ_CIPHER, 8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Register write at the next edge; the predictor copy follows at once.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx <= CSR_KEY_24_31) begin
         key_reg[idx] = value;
      end else if (idx == CSR_KEY_32_35) begin
         key_reg[idx] = {32'h0, value[KEY_TAIL_WIDTH-1:0]};
      end
   endtask

   task automatic release_csr();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until the sender is empty and every expected byte has arrived.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_if.valid || expected_bytes.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      logic [63:0] value;
      logic [CSR_INDEX_WIDTH-1:0] spare_idx;
      int waited;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_CIPHER;
      req_if.data_byte = '0;
      rsp_if.ready     = 1'b0;
      idle_en          = 1'b1;
      mismatch_count   = 0;
      cycle_count      = 0;
      for (int r = 0; r <= CSR_KEY_32_35; r++) begin
         key_reg[r] = '0;
      end
      for (int i = 0; i < LFSR_COUNT; i++) begin
         lfsr_win[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Ciphering before any reload runs on all-zero windows.
      @(negedge clock);
      queue_req(REQ_CIPHER, 8'h00);
      queue_req(REQ_CIPHER, 8'hFF);
      queue_req(REQ_CIPHER, 8'h5A);
      drain();

      // All-ones key; the upper half of the short register and unused indexes are dropped.
      for (int r = 0; r <= CSR_KEY_32_35; r++) begin
         write_csr(CSR_INDEX_WIDTH'(r), '1);
      end
      for (int r = CSR_KEY_32_35 + 1; r < (1 << CSR_INDEX_WIDTH); r++) begin
         write_csr(CSR_INDEX_WIDTH'(r), {$urandom, $urandom});
      end
      release_csr();
      @(negedge clock);
      queue_req(REQ_RELOAD, 8'h00);
      queue_req(REQ_CIPHER, 8'h00);
      queue_req(REQ_CIPHER, 8'hFF);
      queue_req(REQ_CIPHER, 8'h0F);
      queue_req(REQ_CIPHER, 8'hF0);
      queue_req(REQ_RELOAD, 8'hFF);
      queue_req(REQ_CIPHER, 8'h33);
      drain();

      // A key write alone must not disturb the running stream until the next reload.
      write_csr(CSR_KEY_0_7, {$urandom, $urandom});
      release_csr();
      @(negedge clock);
      queue_req(REQ_CIPHER, 8'hC3);
      queue_req(REQ_CIPHER, 8'h3C);
      queue_req(REQ_RELOAD, 8'h00);
      queue_req(REQ_CIPHER, 8'h80);
      queue_req(REQ_CIPHER, 8'h01);
      queue_req(REQ_CIPHER, 8'h7E);
      drain();

      // Random phases under several keys; the last one runs without idling.
      for (int p = 0; p < 5; p++) begin
         for (int r = 0; r <= CSR_KEY_32_35; r++) begin
            case (p)
               1: value = (r % 2 != 0) ? {32{2'b01}} : {32{2'b10}};
               3: value = '0;
               default: value = {$urandom, $urandom};
            endcase
            write_csr(CSR_INDEX_WIDTH'(r), value);
         end
         if (p == 2) begin
            spare_idx = CSR_INDEX_WIDTH'(CSR_KEY_32_35 + 1 + $urandom_range(0, 2));
            write_csr(spare_idx, {$urandom, $urandom});
         end
         release_csr();
         @(negedge clock);
         idle_en = (p != 4);
         queue_req(REQ_RELOAD, 8'($urandom_range(0, 255)));
         queue_random(PHASE_ITEMS);
         if (p != 4) begin
            drain();
         end
      end

      // Final drain with a bound, then a quiet wait before the final check.
      waited = 0;
      while ((pending_reqs.size() != 0 || req_if.valid || expected_bytes.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      if (expected_bytes.size() != 0) begin
         log_mismatch($sformatf("%0d expected cipher bytes never arrived",
                                expected_bytes.size()));
      end

      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
